[sv/pvc_pkg.sv]
// shared types, constants and helpers for the pid position/velocity controller
// no dependencies; imported by every module of the block
package pvc_pkg;

  // default widths for the top-level parameters
  localparam int DATA_WIDTH_DEF     = 16;
  localparam int GAIN_FRAC_BITS_DEF = 8;
  localparam int INTEGRAL_WIDTH_DEF = 24;

  // fixed field widths
  localparam int GAIN_W      = 16;
  localparam int DEADBAND_W  = 16;
  localparam int CFG_INDEX_W = 3;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CONTROL_MODE      = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEADBAND          = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_INTEGRAL      = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_OUT           = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PROPORTIONAL_GAIN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_GAIN     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_DERIVATIVE_GAIN   = 3'd6;

  // control mode codes
  localparam logic MODE_POSITIONAL = 1'b0;
  localparam logic MODE_VELOCITY   = 1'b1;

  // per-stage control: item moves into the stage, controller state is cleared
  typedef struct packed {
    logic load;
    logic clear;
  } pvc_ctrl_t;

  function automatic int maxi(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

[sv/pvc_error_stage.sv]
// error stage: error, error history, deadband test, clamped integral
// and selection of the three multiplier operands; depends on pvc_pkg
module pvc_error_stage import pvc_pkg::*; #(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
  localparam int OP_W          = maxi(DATA_WIDTH + 3, INTEGRAL_WIDTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pvc_ctrl_t                     ctrl,
  input  logic                          control_mode,
  input  logic [DEADBAND_W-1:0]         deadband,
  input  logic [INTEGRAL_WIDTH-2:0]     max_integral,
  input  logic                          ki_nonzero,
  input  logic signed [DATA_WIDTH-1:0]  target,
  input  logic signed [DATA_WIDTH-1:0]  measure,
  output logic                          act,
  output logic signed [OP_W-1:0]        op_p,
  output logic signed [OP_W-1:0]        op_i,
  output logic signed [OP_W-1:0]        op_d
);

  localparam int E_W    = DATA_WIDTH + 1;
  localparam int DE_W   = DATA_WIDTH + 2;
  localparam int DD_W   = DATA_WIDTH + 3;
  localparam int CMP_W  = maxi(E_W, DEADBAND_W);
  localparam int ISUM_W = maxi(INTEGRAL_WIDTH, E_W) + 1;

  logic signed [E_W-1:0]            err_now;
  logic signed [E_W-1:0]            err_last;
  logic signed [E_W-1:0]            err_before_last;
  logic signed [INTEGRAL_WIDTH-1:0] integral;

  logic signed [E_W-1:0]            e;
  logic [E_W-1:0]                   abs_e;
  logic signed [DE_W-1:0]           de;
  logic signed [DD_W-1:0]           dd;
  logic signed [ISUM_W-1:0]         isum;
  logic signed [ISUM_W-1:0]         ilim;
  logic signed [ISUM_W-1:0]         iclamp;
  logic signed [INTEGRAL_WIDTH-1:0] integral_next;
  logic                             act_next;

  assign e     = E_W'(target) - E_W'(measure);
  assign abs_e = e[E_W-1] ? E_W'(-e) : e;
  assign de    = DE_W'(e) - DE_W'(err_now);
  assign dd    = DD_W'(e) - (DD_W'(err_now) <<< 1) + DD_W'(err_last);

  assign act_next = (control_mode == MODE_POSITIONAL) &&
                    (CMP_W'(abs_e) > CMP_W'(deadband));

  // integral accumulate and symmetric clamp; zero gain clears it
  assign isum   = ISUM_W'(integral) + ISUM_W'(e);
  assign ilim   = ISUM_W'({1'b0, max_integral});
  assign iclamp = (isum > ilim) ? ilim : ((isum < -ilim) ? -ilim : isum);
  assign integral_next = ki_nonzero ? iclamp[INTEGRAL_WIDTH-1:0] : '0;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      err_now         <= '0;
      err_last        <= '0;
      err_before_last <= '0;
      integral        <= '0;
    end else if (ctrl.load) begin
      err_now  <= e;
      err_last <= err_now;
      if (control_mode == MODE_VELOCITY) begin
        err_before_last <= err_last;
      end else if (act_next) begin
        integral <= integral_next;
      end
    end
  end

  // operands for kp, ki, kd
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      act <= act_next;
      if (control_mode == MODE_VELOCITY) begin
        op_p <= OP_W'(de);
        op_i <= OP_W'(e);
        op_d <= OP_W'(dd);
      end else begin
        op_p <= OP_W'(e);
        op_i <= OP_W'(integral_next);
        op_d <= OP_W'(de);
      end
    end
  end

endmodule

[sv/pvc_gain_stage.sv]
// gain stage: three signed products, their sum and the fractional shift
// depends on pvc_pkg
module pvc_gain_stage import pvc_pkg::*; #(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
  localparam int OP_W          = maxi(DATA_WIDTH + 3, INTEGRAL_WIDTH),
  localparam int SH_W          = GAIN_W + OP_W + 2 - GAIN_FRAC_BITS
) (
  input  logic                      clk,
  input  pvc_ctrl_t                 ctrl,
  input  logic signed [GAIN_W-1:0]  kp,
  input  logic signed [GAIN_W-1:0]  ki,
  input  logic signed [GAIN_W-1:0]  kd,
  input  logic                      act_in,
  input  logic signed [OP_W-1:0]    op_p,
  input  logic signed [OP_W-1:0]    op_i,
  input  logic signed [OP_W-1:0]    op_d,
  output logic                      act,
  output logic signed [SH_W-1:0]    shifted
);

  localparam int PROD_W = GAIN_W + OP_W;
  localparam int SUM_W  = PROD_W + 2;

  logic signed [PROD_W-1:0] prod_p;
  logic signed [PROD_W-1:0] prod_i;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [SUM_W-1:0]  sum;

  assign prod_p = PROD_W'(kp) * PROD_W'(op_p);
  assign prod_i = PROD_W'(ki) * PROD_W'(op_i);
  assign prod_d = PROD_W'(kd) * PROD_W'(op_d);
  assign sum    = SUM_W'(prod_p) + SUM_W'(prod_i) + SUM_W'(prod_d);

  // dropping the fraction bits floors toward minus infinity
  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      act     <= act_in;
      shifted <= sum[SUM_W-1:GAIN_FRAC_BITS];
    end
  end

endmodule

[sv/pvc_output_stage.sv]
// output stage: held output update, saturation and the drive register
// depends on pvc_pkg
module pvc_output_stage import pvc_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int SH_W       = 2 * DATA_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pvc_ctrl_t                     ctrl,
  input  logic                          control_mode,
  input  logic [DATA_WIDTH-2:0]         max_out,
  input  logic                          act,
  input  logic signed [SH_W-1:0]        shifted,
  output logic signed [DATA_WIDTH-1:0]  drive
);

  localparam int VS_W = maxi(SH_W, DATA_WIDTH) + 1;

  logic signed [VS_W-1:0] vsum;
  logic signed [VS_W-1:0] sel;
  logic signed [VS_W-1:0] olim;
  logic signed [VS_W-1:0] oclamp;

  assign vsum = VS_W'(drive) + VS_W'(shifted);

  // positional: new value when outside the deadband, else hold
  // velocity: accumulate the increment
  assign sel = act ? VS_W'(shifted)
                   : ((control_mode == MODE_VELOCITY) ? vsum : VS_W'(drive));

  assign olim   = VS_W'({1'b0, max_out});
  assign oclamp = (sel > olim) ? olim : ((sel < -olim) ? -olim : sel);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      drive <= '0;
    end else if (ctrl.load) begin
      drive <= oclamp[DATA_WIDTH-1:0];
    end
  end

endmodule

[sv/pid_position_velocity_controller.sv]
// top level of the pid controller: config registers, input register, handshake
// and the error, gain and output stages; depends on pvc_pkg and the pvc_* stages
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   input    | in_valid, in_ready, target, measure | in (valid/ready)
//   result   | out_valid, out_ready, drive      | out (valid/ready)
//   config   | cfg_write, cfg_index, cfg_data   | in (write only)
//
// one item per cycle while the receiver keeps out_ready high; an accepted item
// passes through the input register, error stage, gain stage and drive register
// each stage moves on when the stage after it is empty or moving, so bubbles
// collapse and a stalled drive only holds back items that are behind it
// rst clears the config registers, the error history, the integral and drive
// any config write to a listed register clears the controller state
module pid_position_velocity_controller import pvc_pkg::*; #(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEF,
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF,
  parameter int INTEGRAL_WIDTH = INTEGRAL_WIDTH_DEF,
  localparam int CFG_W         = maxi(maxi(GAIN_W, INTEGRAL_WIDTH - 1), DATA_WIDTH - 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  // input items
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [DATA_WIDTH-1:0]  target,
  input  logic signed [DATA_WIDTH-1:0]  measure,
  // result items
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [DATA_WIDTH-1:0]  drive
);

  localparam int OP_W = maxi(DATA_WIDTH + 3, INTEGRAL_WIDTH);
  localparam int SH_W = GAIN_W + OP_W + 2 - GAIN_FRAC_BITS;

  // configuration registers
  logic                        control_mode;
  logic [DEADBAND_W-1:0]       deadband;
  logic [INTEGRAL_WIDTH-2:0]   max_integral;
  logic [DATA_WIDTH-2:0]       max_out;
  logic signed [GAIN_W-1:0]    proportional_gain;
  logic signed [GAIN_W-1:0]    integral_gain;
  logic signed [GAIN_W-1:0]    derivative_gain;
  logic                        state_clear;

  // pipeline occupancy
  logic in_q_valid;
  logic err_valid;
  logic gain_valid;
  logic err_ready;
  logic gain_ready;
  logic out_stage_ready;

  pvc_ctrl_t err_ctrl;
  pvc_ctrl_t gain_ctrl;
  pvc_ctrl_t out_ctrl;

  // input register
  logic signed [DATA_WIDTH-1:0] target_q;
  logic signed [DATA_WIDTH-1:0] measure_q;

  // stage payloads
  logic                     err_act;
  logic signed [OP_W-1:0]   op_p;
  logic signed [OP_W-1:0]   op_i;
  logic signed [OP_W-1:0]   op_d;
  logic                     gain_act;
  logic signed [SH_W-1:0]   shifted;

  // config decode; an unlisted index is ignored and leaves state alone
  always_comb begin
    case (cfg_index)
      REG_CONTROL_MODE, REG_DEADBAND, REG_MAX_INTEGRAL, REG_MAX_OUT,
      REG_PROPORTIONAL_GAIN, REG_INTEGRAL_GAIN, REG_DERIVATIVE_GAIN: begin
        state_clear = cfg_write;
      end
      default: begin
        state_clear = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode      <= MODE_POSITIONAL;
      deadband          <= '0;
      max_integral      <= '0;
      max_out           <= '0;
      proportional_gain <= '0;
      integral_gain     <= '0;
      derivative_gain   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CONTROL_MODE:      control_mode      <= cfg_data[0];
        REG_DEADBAND:          deadband          <= cfg_data[DEADBAND_W-1:0];
        REG_MAX_INTEGRAL:      max_integral      <= cfg_data[INTEGRAL_WIDTH-2:0];
        REG_MAX_OUT:           max_out           <= cfg_data[DATA_WIDTH-2:0];
        REG_PROPORTIONAL_GAIN: proportional_gain <= cfg_data[GAIN_W-1:0];
        REG_INTEGRAL_GAIN:     integral_gain     <= cfg_data[GAIN_W-1:0];
        REG_DERIVATIVE_GAIN:   derivative_gain   <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ready ripples back from the drive register: a stage takes an item when
  // it is empty or its own item moves on in the same cycle
  assign out_stage_ready = !out_valid || out_ready;
  assign gain_ready      = !gain_valid || out_stage_ready;
  assign err_ready       = !err_valid || gain_ready;
  assign in_ready        = !in_q_valid || err_ready;

  assign err_ctrl  = '{load: in_q_valid && err_ready,       clear: state_clear};
  assign gain_ctrl = '{load: err_valid && gain_ready,       clear: state_clear};
  assign out_ctrl  = '{load: gain_valid && out_stage_ready, clear: state_clear};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
      err_valid  <= 1'b0;
      gain_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        in_q_valid <= in_valid;
      end
      if (err_ready) begin
        err_valid <= in_q_valid;
      end
      if (gain_ready) begin
        gain_valid <= err_valid;
      end
      if (out_stage_ready) begin
        out_valid <= gain_valid;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      target_q  <= target;
      measure_q <= measure;
    end
  end

  pvc_error_stage #(
    .DATA_WIDTH     (DATA_WIDTH),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_error (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (err_ctrl),
    .control_mode (control_mode),
    .deadband     (deadband),
    .max_integral (max_integral),
    .ki_nonzero   (|integral_gain),
    .target       (target_q),
    .measure      (measure_q),
    .act          (err_act),
    .op_p         (op_p),
    .op_i         (op_i),
    .op_d         (op_d)
  );

  pvc_gain_stage #(
    .DATA_WIDTH     (DATA_WIDTH),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_gain (
    .clk     (clk),
    .ctrl    (gain_ctrl),
    .kp      (proportional_gain),
    .ki      (integral_gain),
    .kd      (derivative_gain),
    .act_in  (err_act),
    .op_p    (op_p),
    .op_i    (op_i),
    .op_d    (op_d),
    .act     (gain_act),
    .shifted (shifted)
  );

  pvc_output_stage #(
    .DATA_WIDTH (DATA_WIDTH),
    .SH_W       (SH_W)
  ) u_output (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (out_ctrl),
    .control_mode (control_mode),
    .max_out      (max_out),
    .act          (gain_act),
    .shifted      (shifted),
    .drive        (drive)
  );

`ifndef SYNTH
  // drive never leaves the saturation window
  a_drive_in_range: assert property (@(posedge clk) disable iff (rst)
    ($signed(drive) <= $signed({1'b0, max_out})) &&
    ($signed(drive) >= -$signed({1'b0, max_out})))
    else $error("drive outside +/- max_out");

  // a listed config write clears the held output
  a_cfg_clears_drive: assert property (@(posedge clk) disable iff (rst)
    state_clear |=> (drive == '0))
    else $error("drive not cleared by config write");

  // an item leaving the error stage always lands in the gain stage
  a_gain_stage_loads: assert property (@(posedge clk) disable iff (rst)
    (err_valid && gain_ready) |=> gain_valid)
    else $error("item lost between error and gain stages");
`endif

endmodule

[sim/pid_position_velocity_controller_tb.sv]
// self-checking testbench for pid_position_velocity_controller: directed and random
// items with random idling on both channels, checked against an in-bench controller model
// depends on pvc_pkg and the rtl of the block
module pid_position_velocity_controller_tb import pvc_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int DW  = DATA_WIDTH_DEF;
  localparam int GFB = GAIN_FRAC_BITS_DEF;
  localparam int IW  = INTEGRAL_WIDTH_DEF;
  localparam int CFG_W = maxi(maxi(GAIN_W, IW - 1), DW - 1);

  localparam realtime CLK_PERIOD = 4ns;
  localparam int RESET_CYCLES = 6;
  // an accepted item passes through the input register, error stage, gain stage and drive register
  localparam int LATENCY = 3;
  localparam int MAX_WAIT = 18;
  localparam int RANDOM_ITEMS = 1900;
  localparam longint CYCLE_LIMIT = 400_000;
  localparam int PRINT_LIMIT = 50;

  // index past the last register, must be ignored by the block
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  // pacing styles for the sender and the receiver
  localparam int PACE_FULL   = 0;
  localparam int PACE_RANDOM = 1;
  localparam int PACE_BURSTY = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data  = '0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [DW-1:0] target   = '0;
  logic signed [DW-1:0] measure  = '0;

  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic signed [DW-1:0] drive;

  // drive values still owed by the block, oldest first
  logic signed [DW-1:0] pending_drive[$];

  int     mismatches = 0;
  longint cycle_count = 0;
  int     src_pace = PACE_FULL;
  int     sink_pace = PACE_FULL;

  // controller model: configuration
  logic   ctl_mode = MODE_POSITIONAL;
  longint deadband_r = 0;
  longint max_integral_r = 0;
  longint max_out_r = 0;
  longint kp = 0;
  longint ki = 0;
  longint kd = 0;

  // controller model: state
  longint err_now = 0;
  longint err_prev = 0;
  longint err_prev2 = 0;
  longint err_sum = 0;
  longint drive_acc = 0;

  pid_position_velocity_controller #(
    .DATA_WIDTH    (DW),
    .GAIN_FRAC_BITS(GFB),
    .INTEGRAL_WIDTH(IW)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .target   (target),
    .measure  (measure),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .drive    (drive)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // hard stop in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(string msg);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  function automatic longint clamp_sym(longint v, longint lim);
    if (v > lim)
      return lim;
    if (v < -lim)
      return -lim;
    return v;
  endfunction

  // advance the controller model by one sample and return the saturated drive
  function automatic logic signed [DW-1:0] next_drive(logic signed [DW-1:0] t,
                                                      logic signed [DW-1:0] m);
    longint e;
    longint mag;
    longint gain_sum;
    e = longint'(t) - longint'(m);
    if (ctl_mode == MODE_POSITIONAL) begin
      // second-previous error is left alone in this mode
      err_prev = err_now;
      err_now = e;
      mag = (e < 0) ? -e : e;
      if (mag > deadband_r) begin
        // zero ki disables the integrator and empties it
        if (ki != 0)
          err_sum = clamp_sym(err_sum + e, max_integral_r);
        else
          err_sum = 0;
        gain_sum = kp * e + ki * err_sum + kd * (e - err_prev);
        drive_acc = gain_sum >>> GFB;
      end
    end else begin
      // incremental form: add the change to the last output
      err_prev2 = err_prev;
      err_prev = err_now;
      err_now = e;
      gain_sum = kp * (e - err_prev) + ki * e + kd * (e - 2 * err_prev + err_prev2);
      drive_acc = drive_acc + (gain_sum >>> GFB);
    end
    drive_acc = clamp_sym(drive_acc, max_out_r);
    return drive_acc[DW-1:0];
  endfunction

  function automatic int pick_wait(int pace);
    case (pace)
      PACE_FULL:   return 0;
      PACE_RANDOM: return $urandom_range(0, MAX_WAIT);
      default:     return ($urandom_range(0, 4) == 0) ? $urandom_range(1, MAX_WAIT) : 0;
    endcase
  endfunction

  // one register write; block must be idle. model follows the same rules:
  // low bits only, unknown index ignored, any known index clears the state
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_W-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_CONTROL_MODE:      ctl_mode = v[0];
      REG_DEADBAND:          deadband_r = longint'(v[DEADBAND_W-1:0]);
      REG_MAX_INTEGRAL:      max_integral_r = longint'(v[IW-2:0]);
      REG_MAX_OUT:           max_out_r = longint'(v[DW-2:0]);
      REG_PROPORTIONAL_GAIN: kp = longint'($signed(v[GAIN_W-1:0]));
      REG_INTEGRAL_GAIN:     ki = longint'($signed(v[GAIN_W-1:0]));
      REG_DERIVATIVE_GAIN:   kd = longint'($signed(v[GAIN_W-1:0]));
      default:               idx = REG_UNUSED;
    endcase
    if (idx != REG_UNUSED) begin
      err_now = 0;
      err_prev = 0;
      err_prev2 = 0;
      err_sum = 0;
      drive_acc = 0;
    end
    // keep write enable low before the next write so back-to-back writes stay clean
    @(posedge clk);
  endtask

  // offer one sample after a random gap and wait until it is taken
  task automatic send_sample(logic signed [DW-1:0] t, logic signed [DW-1:0] m);
    int gap;
    gap = pick_wait(src_pace);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    target   <= t;
    measure  <= m;
    do @(posedge clk); while (!in_ready);
    pending_drive.push_back(next_drive(t, m));
  endtask

  // stop sending and let every owed result drain out
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_drive.size() != 0) @(posedge clk);
    repeat (LATENCY + 1) @(posedge clk);
  endtask

  task automatic configure(logic mode, int db, int mi, int mo, int p, int i, int d);
    write_reg(REG_CONTROL_MODE, CFG_W'(mode));
    write_reg(REG_DEADBAND, CFG_W'(db));
    write_reg(REG_MAX_INTEGRAL, CFG_W'(mi));
    write_reg(REG_MAX_OUT, CFG_W'(mo));
    write_reg(REG_PROPORTIONAL_GAIN, CFG_W'(p));
    write_reg(REG_INTEGRAL_GAIN, CFG_W'(i));
    write_reg(REG_DERIVATIVE_GAIN, CFG_W'(d));
  endtask

  // result checker: every accepted drive must match the oldest owed value
  always @(posedge clk) begin
    logic signed [DW-1:0] owed;
    if (!rst && out_valid && out_ready) begin
      if (pending_drive.size() == 0) begin
        report_mismatch($sformatf("unexpected item, drive %0d", drive));
      end else begin
        owed = pending_drive.pop_front();
        if (drive !== owed)
          report_mismatch($sformatf("drive %0d, expected %0d", drive, owed));
      end
    end
  end

  // receiver: random stall before each result, sometimes none at all
  initial begin
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      stall = pick_wait(sink_pace);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // after reset max_out is zero, so even the largest errors give no drive
  task automatic test_reset_defaults();
    src_pace = PACE_FULL;
    sink_pace = PACE_FULL;
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    settle();
  endtask

  // positional form: deadband edge, integral clamp, error extremes,
  // integrator cleared by zero ki and held at zero by a zero clamp
  task automatic test_positional();
    src_pace = PACE_RANDOM;
    sink_pace = PACE_FULL;
    configure(MODE_POSITIONAL, 10, 100, 32767, 256, 128, 64);
    send_sample(16'sd20, 16'sd10);   // error equal to deadband, output held
    send_sample(16'sd21, 16'sd10);   // just outside the deadband
    send_sample(-16'sd5, 16'sd10);
    send_sample(16'sd100, 16'sd0);
    send_sample(16'sd200, 16'sd0);   // integral runs into its clamp
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sd0, 16'sd0);
    settle();
    write_reg(REG_INTEGRAL_GAIN, '0);
    send_sample(16'sd500, 16'sd0);
    send_sample(-16'sd500, 16'sd0);
    settle();
    write_reg(REG_INTEGRAL_GAIN, CFG_W'(256));
    write_reg(REG_MAX_INTEGRAL, '0);
    send_sample(16'sd50, 16'sd0);
    send_sample(16'sd50, 16'sd0);
    settle();
  endtask

  // velocity form accumulating into both saturation limits
  task automatic test_velocity();
    src_pace = PACE_FULL;
    sink_pace = PACE_RANDOM;
    configure(MODE_VELOCITY, 0, 0, 1000, 256, 64, -128);
    send_sample(16'sd100, 16'sd0);
    send_sample(16'sd300, 16'sd0);
    send_sample(16'sh8000, 16'sh7fff);
    send_sample(16'sh7fff, 16'sh8000);
    send_sample(16'sd0, 16'sd0);
    settle();
  endtask

  // unknown index keeps the state, oversized values keep only their low bits,
  // gains at both ends of their range
  task automatic test_register_edges();
    src_pace = PACE_BURSTY;
    sink_pace = PACE_BURSTY;
    send_sample(16'sd10, 16'sd0);
    settle();
    write_reg(REG_UNUSED, '1);
    send_sample(16'sd10, 16'sd0);
    settle();
    write_reg(REG_MAX_OUT, '1);
    write_reg(REG_CONTROL_MODE, 23'h7ffffe);
    write_reg(REG_PROPORTIONAL_GAIN, 23'h7f8000);
    write_reg(REG_INTEGRAL_GAIN, 23'h7f7fff);
    write_reg(REG_DERIVATIVE_GAIN, 23'h008000);
    write_reg(REG_DEADBAND, 23'h7f0000);
    write_reg(REG_MAX_INTEGRAL, '1);
    send_sample(16'sd1, 16'sd0);
    send_sample(-16'sd1, 16'sd0);
    send_sample(16'sh7fff, 16'sh8000);
    settle();
  endtask

  function automatic logic [CFG_W-1:0] with_junk(logic [CFG_W-1:0] v, int w);
    logic [CFG_W-1:0] keep;
    keep = {CFG_W{1'b1}} >> (CFG_W - w);
    if ($urandom_range(0, 3) == 0)
      return (v & keep) | (CFG_W'($urandom()) & ~keep);
    return v & keep;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 16'h8000;
      2:       return 16'h7fff;
      3, 4:    return GAIN_W'($urandom_range(0, 2047) - 1024);
      default: return GAIN_W'($urandom());
    endcase
  endfunction

  // random settings in chunks; half the samples track the target closely so the
  // deadband and the integrator clamp get exercised, the rest are wide open
  task automatic test_random_traffic();
    int sent;
    int chunk;
    logic [CFG_W-1:0] v;
    logic signed [DW-1:0] t;
    logic signed [DW-1:0] m;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      write_reg(REG_CONTROL_MODE, with_junk(CFG_W'($urandom_range(0, 1)), 1));
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = CFG_W'(16'hffff);
        2, 3:    v = CFG_W'($urandom_range(0, 64));
        default: v = CFG_W'($urandom());
      endcase
      write_reg(REG_DEADBAND, with_junk(v, DEADBAND_W));
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = '1;
        2, 3:    v = CFG_W'($urandom_range(0, 5000));
        default: v = CFG_W'($urandom());
      endcase
      write_reg(REG_MAX_INTEGRAL, with_junk(v, IW - 1));
      case ($urandom_range(0, 5))
        0:       v = '0;
        1:       v = CFG_W'(15'h7fff);
        2, 3:    v = CFG_W'($urandom_range(0, 2000));
        default: v = CFG_W'($urandom());
      endcase
      write_reg(REG_MAX_OUT, with_junk(v, DW - 1));
      write_reg(REG_PROPORTIONAL_GAIN, with_junk(CFG_W'(pick_gain()), GAIN_W));
      write_reg(REG_INTEGRAL_GAIN, with_junk(CFG_W'(pick_gain()), GAIN_W));
      write_reg(REG_DERIVATIVE_GAIN, with_junk(CFG_W'(pick_gain()), GAIN_W));
      src_pace = $urandom_range(PACE_FULL, PACE_BURSTY);
      sink_pace = $urandom_range(PACE_FULL, PACE_BURSTY);
      chunk = $urandom_range(20, 120);
      for (int k = 0; k < chunk; k++) begin
        case ($urandom_range(0, 9))
          0:       t = 16'sh8000;
          1:       t = 16'sh7fff;
          default: t = DW'($urandom());
        endcase
        if ($urandom_range(0, 1) == 0)
          m = t + DW'($urandom_range(0, 600) - 300);
        else
          m = DW'($urandom());
        // now and then hold off until everything owed has come back
        if (k == chunk / 2 && $urandom_range(0, 3) == 0)
          settle();
        send_sample(t, m);
      end
      sent += chunk;
    end
    settle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_defaults();
    test_positional();
    test_velocity();
    test_register_edges();
    test_random_traffic();
    settle();
    if (mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
